// ===== hw/rtl/lpht_pkg.sv =====
// shared types and constants for the linear probe hash table
package lpht_pkg;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ZERO_KEY = 2'd2;

    localparam logic [31:0] HASH_MUL_A = 32'h85ebca6b;
    localparam logic [31:0] HASH_MUL_B = 32'hc2b2ae35;

    localparam int HOME_W      = 16;
    localparam int CNT_CMP_W   = 17;
    localparam logic [10:0] COUNT_MAX = 11'd2047;

    typedef enum logic [2:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_CLEAR,
        OP_NOP,
        OP_ZERO
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [63:0]        key;
        logic [63:0]        value;
        logic [30:0]        size;
        logic [HOME_W-1:0]  home;
    } cmd_t;

endpackage

// ===== hw/rtl/lpht_ram.sv =====
// generic single write port ram with registered read
module lpht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/lpht_front.sv =====
// front end: accepts transactions, classifies them and computes the home slot
module lpht_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          kind,
    input  logic [63:0]         lookup_key,
    input  logic [63:0]         new_value,
    input  logic [30:0]         entry_size,
    input  logic                hold,
    output logic                cmd_valid,
    output lpht_pkg::cmd_t      cmd,
    input  logic                cmd_ready
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL_LO,
        F_MUL_HI,
        F_PUSH
    } fstate_t;

    fstate_t        state_reg, state_next;
    logic           sel_reg, sel_next;
    logic [63:0]    h_reg, h_next;
    logic [63:0]    prod_reg, prod_next;
    lpht_pkg::cmd_t cmd_reg, cmd_next;
    logic [31:0]    mul_c;
    logic [31:0]    mul_a;
    logic [63:0]    mul_p;
    logic [63:0]    sum;

    assign mul_c = sel_reg ? lpht_pkg::HASH_MUL_B : lpht_pkg::HASH_MUL_A;
    assign mul_a = (state_reg == F_MUL_LO) ? h_reg[31:0] : h_reg[63:32];
    assign mul_p = mul_a * mul_c;
    assign sum   = prod_reg + {mul_p[31:0], 32'd0};

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        h_next     = h_reg;
        prod_next  = prod_reg;
        cmd_next   = cmd_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push && !hold)
                begin
                    h_next         = lookup_key ^ (lookup_key >> 2);
                    sel_next       = 1'b0;
                    cmd_next.key   = lookup_key;
                    cmd_next.value = new_value;
                    cmd_next.size  = entry_size;
                    priority if (kind == lpht_pkg::KIND_CLEAR)
                        cmd_next.op = lpht_pkg::OP_CLEAR;
                    else if (kind != lpht_pkg::KIND_LOOKUP && kind != lpht_pkg::KIND_INSERT)
                        cmd_next.op = lpht_pkg::OP_NOP;
                    else if (lookup_key == 64'd0)
                        cmd_next.op = lpht_pkg::OP_ZERO;
                    else if (kind == lpht_pkg::KIND_LOOKUP)
                        cmd_next.op = lpht_pkg::OP_LOOKUP;
                    else
                        cmd_next.op = lpht_pkg::OP_INSERT;
                    state_next = F_MUL_LO;
                end
            end
            F_MUL_LO:
            begin
                prod_next  = mul_p;
                state_next = F_MUL_HI;
            end
            F_MUL_HI:
            begin
                if (sel_reg)
                begin
                    h_next        = sum ^ (sum >> 16);
                    cmd_next.home = h_next[lpht_pkg::HOME_W-1:0];
                    state_next    = F_PUSH;
                end
                else
                begin
                    h_next     = sum ^ (sum >> 13);
                    sel_next   = 1'b1;
                    state_next = F_MUL_LO;
                end
            end
            F_PUSH:
            begin
                if (cmd_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            sel_reg   <= 1'b0;
            h_reg     <= '0;
            prod_reg  <= '0;
            cmd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            h_reg     <= h_next;
            prod_reg  <= prod_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign full      = (state_reg != F_IDLE) || hold;
    assign cmd_valid = (state_reg == F_PUSH);
    assign cmd       = cmd_reg;

endmodule

// ===== hw/rtl/lpht_queue.sv =====
// two entry command queue between front and back
module lpht_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lpht_pkg::cmd_t in_cmd,
    output logic           out_valid,
    output lpht_pkg::cmd_t out_cmd,
    input  logic           out_pop
);

    lpht_pkg::cmd_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           do_push, do_pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_pop && out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

// ===== hw/rtl/lpht_back.sv =====
// back end: probes the slot memories, updates the table and holds the result
module lpht_back #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    output logic           init_busy,
    input  logic           q_valid,
    input  lpht_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic           found,
    output logic [63:0]    read_value,
    output logic [30:0]    read_size,
    output logic [1:0]     status,
    output logic [10:0]    item_count
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        B_INIT,
        B_IDLE,
        B_PROBE,
        B_CLR
    } bstate_t;

    bstate_t        state_reg, state_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [IW-1:0]  probe_reg, probe_next;
    logic [CW-1:0]  count_reg, count_next;
    lpht_pkg::cmd_t ent_reg, ent_next;
    logic           out_valid_reg, out_valid_next;
    logic           found_reg, found_next;
    logic [63:0]    value_reg, value_next;
    logic [30:0]    size_reg, size_next;
    logic [1:0]     status_reg, status_next;
    logic [10:0]    cnt_out_reg, cnt_out_next;

    logic           out_free;
    logic           key_we, data_we;
    logic [63:0]    key_wdata;
    logic [IW-1:0]  raddr;
    logic [63:0]    key_rd, val_rd;
    logic [30:0]    size_rd;
    logic           hit, vacant;

    lpht_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_keys (
        .clk(clk), .we(key_we), .waddr(idx_reg), .wdata(key_wdata),
        .raddr(raddr), .rdata(key_rd)
    );
    lpht_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_values (
        .clk(clk), .we(data_we), .waddr(idx_reg), .wdata(ent_reg.value),
        .raddr(raddr), .rdata(val_rd)
    );
    lpht_ram #(.WIDTH(31), .DEPTH(TABLE_ENTRIES)) u_sizes (
        .clk(clk), .we(data_we), .waddr(idx_reg), .wdata(ent_reg.size),
        .raddr(raddr), .rdata(size_rd)
    );

    function automatic logic [10:0] sat_count(input logic [CW-1:0] c);
        logic [lpht_pkg::CNT_CMP_W-1:0] w;
        w = lpht_pkg::CNT_CMP_W'(c);
        if (w > lpht_pkg::CNT_CMP_W'(lpht_pkg::COUNT_MAX))
            return lpht_pkg::COUNT_MAX;
        return w[10:0];
    endfunction

    function automatic logic CNT_CMP_W_CHECK(input logic [CW-1:0] c);
        return (lpht_pkg::CNT_CMP_W'(c) <= lpht_pkg::CNT_CMP_W'(TABLE_ENTRIES));
    endfunction

    assign out_free = !out_valid_reg || pop;
    assign hit      = (key_rd == ent_reg.key);
    assign vacant   = (key_rd == 64'd0);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        probe_next     = probe_reg;
        count_next     = count_reg;
        ent_next       = ent_reg;
        out_valid_next = out_valid_reg && !pop;
        found_next     = found_reg;
        value_next     = value_reg;
        size_next      = size_reg;
        status_next    = status_reg;
        cnt_out_next   = cnt_out_reg;
        q_pop          = 1'b0;
        key_we         = 1'b0;
        data_we        = 1'b0;
        key_wdata      = 64'd0;
        raddr          = idx_reg;
        unique case (state_reg)
            B_INIT, B_CLR:
            begin
                key_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST)
                begin
                    idx_next = '0;
                    if (state_reg == B_CLR)
                    begin
                        out_valid_next = 1'b1;
                        found_next     = 1'b0;
                        value_next     = 64'd0;
                        size_next      = 31'd0;
                        status_next    = lpht_pkg::ST_OK;
                        cnt_out_next   = 11'd0;
                    end
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop      = 1'b1;
                    ent_next   = q_cmd;
                    found_next = 1'b0;
                    value_next = 64'd0;
                    size_next  = 31'd0;
                    unique case (q_cmd.op)
                        lpht_pkg::OP_LOOKUP, lpht_pkg::OP_INSERT:
                        begin
                            idx_next   = q_cmd.home[IW-1:0];
                            raddr      = q_cmd.home[IW-1:0];
                            probe_next = '0;
                            state_next = B_PROBE;
                        end
                        lpht_pkg::OP_CLEAR:
                        begin
                            idx_next   = '0;
                            count_next = '0;
                            state_next = B_CLR;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = (q_cmd.op == lpht_pkg::OP_ZERO) ?
                                             lpht_pkg::ST_ZERO_KEY : lpht_pkg::ST_OK;
                            cnt_out_next   = sat_count(count_reg);
                        end
                    endcase
                end
            end
            B_PROBE:
            begin
                priority if (hit || vacant)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lpht_pkg::ST_OK;
                    found_next     = hit;
                    if (ent_reg.op == lpht_pkg::OP_LOOKUP)
                    begin
                        value_next = hit ? val_rd : 64'd0;
                        size_next  = hit ? size_rd : 31'd0;
                        cnt_out_next = sat_count(count_reg);
                    end
                    else
                    begin
                        data_we   = 1'b1;
                        key_we    = !hit;
                        key_wdata = ent_reg.key;
                        if (!hit)
                            count_next = count_reg + 1'b1;
                        cnt_out_next = sat_count(count_next);
                    end
                    state_next = B_IDLE;
                end
                else if (probe_reg == LAST)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lpht_pkg::ST_FULL;
                    cnt_out_next   = sat_count(count_reg);
                    state_next     = B_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    raddr      = idx_next;
                    probe_next = probe_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            idx_reg       <= '0;
            probe_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            ent_reg       <= '0;
            found_reg     <= 1'b0;
            value_reg     <= '0;
            size_reg      <= '0;
            status_reg    <= lpht_pkg::ST_OK;
            cnt_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            probe_reg     <= probe_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            ent_reg       <= ent_next;
            found_reg     <= found_next;
            value_reg     <= value_next;
            size_reg      <= size_next;
            status_reg    <= status_next;
            cnt_out_reg   <= cnt_out_next;
        end
    end

    assign init_busy  = (state_reg == B_INIT);
    assign empty      = !out_valid_reg;
    assign found      = found_reg;
    assign read_value = value_reg;
    assign read_size  = size_reg;
    assign status     = status_reg;
    assign item_count = cnt_out_reg;

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLR || state_reg == B_INIT) |-> !q_pop)
        else $error("queue popped during clearing pass");

    a_result_slot_free_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PROBE) |-> !out_valid_reg)
        else $error("result pending while probing");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_CMP_W_CHECK(count_reg))
        else $error("stored count beyond table size");

endmodule

// ===== hw/rtl/linear_probe_hash_table.sv =====
// top level of the linear probe hash table
//
// input channel: push/full with kind, lookup_key, new_value, entry_size; a
// transaction is taken when push is high and full is low
// result channel: empty/pop with found, read_value, read_size, status,
// item_count; one result per transaction, in order
// the front hashes each key on one shared 32x32 multiplier, passing twice
// through F_MUL_LO and F_MUL_HI, then hands the command to a two entry queue
// the back probes the key, value and size memories one slot per cycle;
// a lookup or insert probes from the home slot until a hit, a vacant slot or
// a full pass over the table, a clear zeroes every key slot, and other kinds
// give their result straight from idle
// the front takes a new transaction only once it has handed the last one on
// after reset the back clears the key memory, writing every slot, while full
// stays high
// when the result is not popped the back holds, the queue fills, and full
// rises; nothing is dropped
module linear_probe_hash_table #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [63:0] lookup_key,
    input  logic [63:0] new_value,
    input  logic [30:0] entry_size,
    output logic        empty,
    input  logic        pop,
    output logic        found,
    output logic [63:0] read_value,
    output logic [30:0] read_size,
    output logic [1:0]  status,
    output logic [10:0] item_count
);

    logic           init_busy;
    logic           f_valid, f_ready;
    lpht_pkg::cmd_t f_cmd;
    logic           q_valid, q_pop;
    lpht_pkg::cmd_t q_cmd;

    lpht_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .lookup_key(lookup_key), .new_value(new_value), .entry_size(entry_size),
        .hold(init_busy), .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
    );

    lpht_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_ready(f_ready),
        .in_cmd(f_cmd), .out_valid(q_valid), .out_cmd(q_cmd), .out_pop(q_pop)
    );

    lpht_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .init_busy(init_busy), .q_valid(q_valid),
        .q_cmd(q_cmd), .q_pop(q_pop), .empty(empty), .pop(pop), .found(found),
        .read_value(read_value), .read_size(read_size), .status(status),
        .item_count(item_count)
    );

endmodule

// ===== tb/sv/lpht_checker.sv =====
// checker that predicts the hash table results and compares them
`timescale 1ns / 100ps
module lpht_checker #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  kind,
    input  logic [63:0] lookup_key,
    input  logic [63:0] new_value,
    input  logic [30:0] entry_size,
    input  logic        empty,
    input  logic        pop,
    input  logic        found,
    input  logic [63:0] read_value,
    input  logic [30:0] read_size,
    input  logic [1:0]  status,
    input  logic [10:0] item_count,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic        found;
        logic [63:0] value;
        logic [30:0] size;
        logic [1:0]  status;
        logic [10:0] count;
    } answer_t;

    logic [63:0] shadow_keys [TABLE_ENTRIES];
    logic [63:0] shadow_values [TABLE_ENTRIES];
    logic [30:0] shadow_sizes [TABLE_ENTRIES];
    int unsigned shadow_count;
    answer_t answers_due[$];

    function automatic logic [63:0] home_hash(logic [63:0] k);
        logic [63:0] h;
        h = k;
        h = h ^ (h >> 2);
        h = h * 64'h85ebca6b;
        h = h ^ (h >> 13);
        h = h * 64'hc2b2ae35;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic answer_t table_access(logic [1:0] op, logic [63:0] k,
                                             logic [63:0] v, logic [30:0] sz);
        answer_t a;
        logic [63:0] h;
        int idx;
        bit hit;
        a = '0;
        hit = 0;
        idx = 0;
        if (op == lpht_pkg::KIND_CLEAR)
        begin
            foreach (shadow_keys[i])
            begin
                shadow_keys[i] = '0;
                shadow_values[i] = '0;
                shadow_sizes[i] = '0;
            end
            shadow_count = 0;
        end
        else if (op == lpht_pkg::KIND_LOOKUP || op == lpht_pkg::KIND_INSERT)
        begin
            if (k == 0)
                a.status = lpht_pkg::ST_ZERO_KEY;
            else
            begin
                h = home_hash(k);
                for (int i = 0; i < TABLE_ENTRIES && !hit; i++)
                begin
                    idx = int'((h + 64'(i)) & 64'(TABLE_ENTRIES - 1));
                    if (shadow_keys[idx] == k || shadow_keys[idx] == 0)
                        hit = 1;
                end
                if (!hit)
                    a.status = lpht_pkg::ST_FULL;
                else if (op == lpht_pkg::KIND_LOOKUP)
                begin
                    if (shadow_keys[idx] == k)
                    begin
                        a.found = 1;
                        a.value = shadow_values[idx];
                        a.size = shadow_sizes[idx];
                    end
                end
                else
                begin
                    if (shadow_keys[idx] == k)
                        a.found = 1;
                    else
                    begin
                        shadow_keys[idx] = k;
                        shadow_count++;
                    end
                    shadow_values[idx] = v;
                    shadow_sizes[idx] = sz;
                end
            end
        end
        a.count = shadow_count > 2047 ? lpht_pkg::COUNT_MAX : 11'(shadow_count);
        return a;
    endfunction

    assign pending = answers_due.size();

    initial
    begin
        foreach (shadow_keys[i])
        begin
            shadow_keys[i] = '0;
            shadow_values[i] = '0;
            shadow_sizes[i] = '0;
        end
        shadow_count = 0;
        fail_count = 0;
    end

    always @(posedge clk)
    begin
        answer_t want;
        answer_t got;
        if (rst_n && push && !full)
            answers_due.push_back(table_access(kind, lookup_key, new_value, entry_size));
        if (rst_n && pop && !empty)
        begin
            got = {found, read_value, read_size, status, item_count};
            if (answers_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result transaction %h", got);
            end
            else
            begin
                want = answers_due.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch: found %b/%b value %h/%h size %h/%h",
                                 want.found, got.found, want.value, got.value,
                                 want.size, got.size);
                        $display("          status %0d/%0d count %0d/%0d",
                                 want.status, got.status, want.count, got.count);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_linear_probe_hash_table.sv =====
// testbench top for the linear probe hash table
`timescale 1ns / 100ps
module tb_linear_probe_hash_table;

    localparam int ENTRIES = 1024;
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  kind;
    logic [63:0] lookup_key;
    logic [63:0] new_value;
    logic [30:0] entry_size;
    logic        empty;
    logic        pop;
    logic        found;
    logic [63:0] read_value;
    logic [30:0] read_size;
    logic [1:0]  status;
    logic [10:0] item_count;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_results;
    int          quiet_cycles;
    logic [63:0] key_pool [32];

    linear_probe_hash_table #(.TABLE_ENTRIES(ENTRIES)) DUT (.*);

    lpht_checker #(.TABLE_ENTRIES(ENTRIES)) checker_i (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_results)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_op(logic [1:0] k, logic [63:0] key, logic [63:0] v, logic [30:0] sz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        kind <= k;
        lookup_key <= key;
        new_value <= v;
        entry_size <= sz;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic random_op();
        int r;
        logic [63:0] key;
        r = $urandom_range(99);
        key = key_pool[$urandom_range(31)];
        if (r < 3)
            key = {$urandom, $urandom};
        else if (r < 5)
            key = 64'd0;
        r = $urandom_range(199);
        if (r == 0)
            send_op(lpht_pkg::KIND_CLEAR, {$urandom, $urandom}, {$urandom, $urandom},
                    31'($urandom));
        else if (r == 1)
            send_op(lpht_pkg::KIND_UNUSED, key, {$urandom, $urandom}, 31'($urandom));
        else
            send_op(r < 100 ? lpht_pkg::KIND_INSERT : lpht_pkg::KIND_LOOKUP, key,
                    {$urandom, $urandom}, 31'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        kind = lpht_pkg::KIND_LOOKUP;
        lookup_key = '0;
        new_value = '0;
        entry_size = '0;
        hold_results = 0;
        quiet_cycles = 0;
        send_idle_pct = 15;
        recv_idle_pct = 76;
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        key_pool[1] = 64'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every kind, zero key, update, clear
        send_op(lpht_pkg::KIND_LOOKUP, 64'd1, '0, '0);
        send_op(lpht_pkg::KIND_INSERT, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
        send_op(lpht_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 31'd0);
        send_op(lpht_pkg::KIND_LOOKUP, 64'd1, '0, '0);
        send_op(lpht_pkg::KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        send_op(lpht_pkg::KIND_INSERT, 64'd1, 64'h0123_4567_89AB_CDEF, 31'h2AAA_AAAA);
        send_op(lpht_pkg::KIND_LOOKUP, 64'd1, '0, '0);
        send_op(lpht_pkg::KIND_INSERT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 31'h7FFF_FFFF);
        send_op(lpht_pkg::KIND_LOOKUP, 64'd0, '0, '0);
        send_op(lpht_pkg::KIND_UNUSED, 64'd1, 64'd5, 31'd5);
        send_op(lpht_pkg::KIND_LOOKUP, 64'hDEAD_BEEF_0000_0001, '0, '0);
        send_op(lpht_pkg::KIND_CLEAR, '0, '0, '0);
        send_op(lpht_pkg::KIND_LOOKUP, 64'd1, '0, '0);

        // long receiver hold-off so the block backs up
        hold_results = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_results = 0;
            end
            begin
                repeat (12) random_op();
                push <= 1'b0;
            end
        join
        @(posedge clk);

        for (int i = 0; i < 700; i++)
        begin
            if (i == 233)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 15;
            end
            else if (i == 466)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_op();
        end

        // fill the table with fresh keys to reach the full status
        send_op(lpht_pkg::KIND_CLEAR, '0, '0, '0);
        for (int i = 0; i < ENTRIES + 3; i++)
            send_op(lpht_pkg::KIND_INSERT, {$urandom, $urandom} | 64'd1,
                    {$urandom, $urandom}, 31'($urandom));
        send_op(lpht_pkg::KIND_LOOKUP, 64'h5555_5555_5555_5554, '0, '0);
        send_op(lpht_pkg::KIND_LOOKUP, key_pool[0], '0, '0);
        push <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (ENTRIES + 50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
